[rtl/core/isrch_pkg.sv]
// Shared widths and constants for the interpolation search table.
`timescale 1ns / 1ps

package isrch_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = 10;
    localparam int VAL_W       = 31;
    localparam int CNT_W       = 11;
    localparam int QUO_W       = 10;
    localparam int PROD_W      = VAL_W + QUO_W;
    localparam int STEP_W      = $clog2(QUO_W + 1);

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

endpackage

[rtl/core/isrch_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module isrch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/isrch_div.sv]
// Restoring divider, one quotient bit per cycle; quotient known to fit QUO_W bits.
`timescale 1ns / 1ps

module isrch_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [isrch_pkg::PROD_W-1:0]  dividend,
    input  logic [isrch_pkg::VAL_W-1:0]   divisor,
    output logic                          done,
    output logic [isrch_pkg::QUO_W-1:0]   quotient
);

    logic [isrch_pkg::VAL_W-1:0]  rem_reg,  rem_next;
    logic [isrch_pkg::QUO_W-1:0]  dq_reg,   dq_next;
    logic [isrch_pkg::VAL_W-1:0]  den_reg,  den_next;
    logic [isrch_pkg::STEP_W-1:0] cnt_reg,  cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [isrch_pkg::VAL_W:0]    trial;
    logic                         fits;

    // dividend < divisor << QUO_W, so the top part starts below the divisor
    assign trial = {rem_reg, dq_reg[isrch_pkg::QUO_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[isrch_pkg::PROD_W-1:isrch_pkg::QUO_W];
            dq_next   = dividend[isrch_pkg::QUO_W-1:0];
            den_next  = divisor;
            cnt_next  = isrch_pkg::STEP_W'(isrch_pkg::QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? isrch_pkg::VAL_W'(trial - {1'b0, den_reg})
                            : trial[isrch_pkg::VAL_W-1:0];
            dq_next  = {dq_reg[isrch_pkg::QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == isrch_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

[rtl/core/interpolation_search_table_core.sv]
// Interpolation search over a loadable table of ascending counts.
//
// Input channel (in_valid / in_stall) carries mode, index and value. Mode 0
// writes value into table entry index in the transfer cycle and gives no
// result. Mode 1 searches entries 0 .. entries_in_use-1 for the key value and
// gives one result (found, position) on the output channel.
// Configuration: cfg_wen with cfg_wdata sets entries_in_use (saturated to the
// table depth); write it only while the block is idle.
// A load is written in its transfer cycle and does not stall the input, so
// another item can follow it directly. A search runs, for each probe, three
// table reads through the single read port, a multiply and a restoring divide;
// a probe with equal window ends skips the multiply and divide. One item is
// worked on at a time: in_stall is high from the transfer of a search until its
// result is registered.
// The result waits in an output register; a new item is taken while it is
// stalled, but the next search result waits for the register to empty.
// Reset clears control state and entries_in_use; table contents are undefined
// until loaded.
`timescale 1ns / 1ps

module interpolation_search_table_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [isrch_pkg::CNT_W-1:0]  cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic [isrch_pkg::IDX_W-1:0]  index,
    input  logic [isrch_pkg::VAL_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         found,
    output logic [isrch_pkg::IDX_W-1:0]  position
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOP = 3'd1;
    localparam logic [2:0] S_RDR  = 3'd2;
    localparam logic [2:0] S_TEST = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]                    state_reg,   state_next;
    logic [isrch_pkg::CNT_W-1:0]   entries_reg;
    logic [isrch_pkg::CNT_W-1:0]   lo_reg,      lo_next;
    logic [isrch_pkg::CNT_W-1:0]   hip1_reg,    hip1_next;   // right end plus one
    logic [isrch_pkg::VAL_W-1:0]   key_reg,     key_next;
    logic [isrch_pkg::VAL_W-1:0]   tl_reg,      tl_next;
    logic [isrch_pkg::VAL_W-1:0]   diff_reg,    diff_next;
    logic [isrch_pkg::IDX_W-1:0]   span_reg,    span_next;
    logic [isrch_pkg::VAL_W-1:0]   den_reg,     den_next;
    logic [isrch_pkg::IDX_W-1:0]   pos_reg,     pos_next;
    logic                          pos_ok_reg,  pos_ok_next; // probe position settled
    logic                          hit_reg,     hit_next;
    logic [isrch_pkg::IDX_W-1:0]   hitpos_reg,  hitpos_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          found_reg,   found_next;
    logic [isrch_pkg::IDX_W-1:0]   position_reg, position_next;

    logic                          in_xfer;
    logic                          ram_we;
    logic [isrch_pkg::IDX_W-1:0]   ram_raddr;
    logic [isrch_pkg::VAL_W-1:0]   ram_rdata;
    logic [isrch_pkg::CNT_W-1:0]   n_eff;
    logic [isrch_pkg::CNT_W-1:0]   hi;
    logic                          div_start;
    logic                          div_done;
    logic [isrch_pkg::QUO_W-1:0]   div_quo;
    logic [isrch_pkg::PROD_W-1:0]  product;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign ram_we   = in_xfer && (mode == isrch_pkg::MODE_LOAD);

    assign n_eff = (entries_reg > isrch_pkg::CNT_W'(isrch_pkg::TABLE_DEPTH))
                 ? isrch_pkg::CNT_W'(isrch_pkg::TABLE_DEPTH) : entries_reg;
    assign hi    = hip1_reg - 1'b1;

    assign product   = isrch_pkg::PROD_W'(diff_reg) * isrch_pkg::PROD_W'(span_reg);
    assign div_start = (state_reg == S_MUL);

    always_comb
    begin
        unique case (state_reg)
            S_RDR:   ram_raddr = hi[isrch_pkg::IDX_W-1:0];
            S_DIV,
            S_CMP:   ram_raddr = pos_reg;
            default: ram_raddr = lo_reg[isrch_pkg::IDX_W-1:0];
        endcase
    end

    isrch_ram #(
        .WIDTH (isrch_pkg::VAL_W),
        .DEPTH (isrch_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (index),
        .wdata (value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    isrch_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next    = state_reg;
        lo_next       = lo_reg;
        hip1_next     = hip1_reg;
        key_next      = key_reg;
        tl_next       = tl_reg;
        diff_next     = diff_reg;
        span_next     = span_reg;
        den_next      = den_reg;
        pos_next      = pos_reg;
        pos_ok_next   = pos_ok_reg;
        hit_next      = hit_reg;
        hitpos_next   = hitpos_reg;
        found_next    = found_reg;
        position_next = position_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (mode == isrch_pkg::MODE_SEARCH))
                begin
                    lo_next    = '0;
                    hip1_next  = n_eff;
                    key_next   = value;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (lo_reg >= hip1_reg)
                begin
                    hit_next    = 1'b0;
                    hitpos_next = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_RDR;
                end
            end
            S_RDR:
            begin
                tl_next    = ram_rdata;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                // ram_rdata holds the right end of the window here
                if ((key_reg < tl_reg) || (key_reg > ram_rdata))
                begin
                    hit_next    = 1'b0;
                    hitpos_next = '0;
                    state_next  = S_DONE;
                end
                else if (ram_rdata == tl_reg)
                begin
                    pos_next    = lo_reg[isrch_pkg::IDX_W-1:0];
                    pos_ok_next = 1'b1;
                    state_next  = S_DIV;
                end
                else
                begin
                    diff_next   = key_reg - tl_reg;
                    span_next   = hi[isrch_pkg::IDX_W-1:0] - lo_reg[isrch_pkg::IDX_W-1:0];
                    den_next    = ram_rdata - tl_reg;
                    pos_ok_next = 1'b0;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // also entered straight from S_TEST with the probe already set
                if (div_done)
                begin
                    pos_next    = lo_reg[isrch_pkg::IDX_W-1:0] + div_quo;
                    pos_ok_next = 1'b1;
                end
                else if (pos_ok_reg)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (ram_rdata == key_reg)
                begin
                    hit_next    = 1'b1;
                    hitpos_next = pos_reg;
                    state_next  = S_DONE;
                end
                else if (ram_rdata > key_reg)
                begin
                    hip1_next  = {1'b0, pos_reg};
                    state_next = S_LOOP;
                end
                else
                begin
                    lo_next    = {1'b0, pos_reg} + 1'b1;
                    state_next = S_LOOP;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    position_next  = hitpos_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            entries_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                entries_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hip1_reg     <= hip1_next;
        key_reg      <= key_next;
        tl_reg       <= tl_next;
        diff_reg     <= diff_next;
        span_reg     <= span_next;
        den_reg      <= den_next;
        pos_reg      <= pos_next;
        pos_ok_reg   <= pos_ok_next;
        hit_reg      <= hit_next;
        hitpos_reg   <= hitpos_next;
        found_reg    <= found_next;
        position_reg <= position_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

endmodule

[test/interpolation_search_table_core_tb.sv]
// Self-checking testbench for the interpolation search table core.
`timescale 1ns / 1ps

module interpolation_search_table_core_tb;

    localparam longint COUNT_MAX   = 64'h7FFF_FFFF;
    localparam int     ITEM_TARGET = 1850;
    localparam int     QUIET_FROM  = 1600;

    typedef struct packed {
        logic                        hit;
        logic [isrch_pkg::IDX_W-1:0] where;
        logic [isrch_pkg::VAL_W-1:0] key;
    } lookup_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wen;
    logic [isrch_pkg::CNT_W-1:0] cfg_wdata;
    logic                        in_valid;
    logic                        in_stall;
    logic                        mode;
    logic [isrch_pkg::IDX_W-1:0] index;
    logic [isrch_pkg::VAL_W-1:0] value;
    logic                        out_valid;
    logic                        out_stall;
    logic                        found;
    logic [isrch_pkg::IDX_W-1:0] position;

    // local copy of the table and of the window register
    logic [isrch_pkg::VAL_W-1:0] count_table [isrch_pkg::TABLE_DEPTH];
    logic [isrch_pkg::CNT_W-1:0] window_entries;
    lookup_t                     pending_lookups [$];
    int                          mismatches;
    int                          items_sent;
    bit                          quiet;

    interpolation_search_table_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .index     (index),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .position  (position)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000_000;
        $display("interpolation_search_table_core_tb failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void interpolate_lookup(input logic [isrch_pkg::VAL_W-1:0] key_in,
                                               output logic hit,
                                               output logic [isrch_pkg::IDX_W-1:0] where);
        longint n, lo, hi, k, tl, tr, tp, probe;
        bit     done;
        n = (window_entries > isrch_pkg::TABLE_DEPTH) ? isrch_pkg::TABLE_DEPTH
                                                      : window_entries;
        lo = 0;
        hi = n - 1;
        k = key_in;
        hit = 1'b0;
        where = '0;
        done = 1'b0;
        while (!done && lo <= hi)
        begin
            tl = count_table[lo];
            tr = count_table[hi];
            if (k < tl || k > tr)
                done = 1'b1;
            else
            begin
                // equal ends: probe at the left end, no divide
                probe = (tr == tl) ? lo : lo + ((k - tl) * (hi - lo)) / (tr - tl);
                tp = count_table[probe];
                if (tp == k)
                begin
                    hit = 1'b1;
                    where = probe[isrch_pkg::IDX_W-1:0];
                    done = 1'b1;
                end
                else if (tp > k)
                    hi = probe - 1;
                else
                    lo = probe + 1;
            end
        end
    endfunction

    // Drives one item from a falling edge and returns at the falling edge
    // after its transfer; valid stays high for a following item.
    task automatic send_item(input logic m, input logic [isrch_pkg::IDX_W-1:0] idx,
                             input logic [isrch_pkg::VAL_W-1:0] val);
        lookup_t r;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        index    <= idx;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (m == isrch_pkg::MODE_LOAD)
            count_table[idx] = val;
        else
        begin
            interpolate_lookup(val, r.hit, r.where);
            r.key = val;
            pending_lookups.push_back(r);
        end
        items_sent++;
        @(negedge clk);
    endtask

    // Wait for every outstanding search, then let a trailing load finish.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_window(input logic [isrch_pkg::CNT_W-1:0] entries);
        quiesce();
        cfg_wen   <= 1'b1;
        cfg_wdata <= entries;
        window_entries = entries;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    // kind: 0 ascending by random steps, 1 growing steps, 2 all equal, 3 unsorted
    task automatic fill_table(input int n, input int kind, input int unsigned span);
        longint level, step;
        level = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, span);
        step = 1;
        for (int i = 0; i < n; i++)
        begin
            if (kind == 3)
                level = $urandom & COUNT_MAX;
            if (level > COUNT_MAX)
                level = COUNT_MAX;
            send_item(isrch_pkg::MODE_LOAD, i[isrch_pkg::IDX_W-1:0],
                      level[isrch_pkg::VAL_W-1:0]);
            if (kind == 0)
                level += $urandom_range(0, span);
            else if (kind == 1)
            begin
                level += step;
                step = step * 2 + $urandom_range(0, 3);
            end
        end
    endtask

    function automatic logic [isrch_pkg::VAL_W-1:0] pick_key();
        int                          n;
        logic [isrch_pkg::VAL_W-1:0] k;
        n = (window_entries > isrch_pkg::TABLE_DEPTH) ? isrch_pkg::TABLE_DEPTH
                                                      : window_entries;
        k = isrch_pkg::VAL_W'($urandom);
        if (n > 0)
            k = count_table[$urandom_range(0, n - 1)];
        case ($urandom_range(0, 9))
            5: k = k + 1'b1;
            6: k = k - 1'b1;
            7: k = isrch_pkg::VAL_W'($urandom);
            8: k = $urandom_range(0, 1) ? '0 : '1;
            9: k = isrch_pkg::VAL_W'($urandom_range(0, 255));
            default: ;
        endcase
        return k;
    endfunction

    task automatic test_empty_table();
        // window is zero out of reset
        send_item(isrch_pkg::MODE_SEARCH, '0, '1);
        set_window('0);
        send_item(isrch_pkg::MODE_SEARCH, '0, '0);
    endtask

    task automatic test_directed();
        send_item(isrch_pkg::MODE_LOAD, 10'd0, 31'd0);
        send_item(isrch_pkg::MODE_LOAD, 10'd1, 31'd5);
        send_item(isrch_pkg::MODE_LOAD, 10'd2, 31'd5);
        send_item(isrch_pkg::MODE_LOAD, 10'd3, 31'd100);
        send_item(isrch_pkg::MODE_LOAD, 10'd4, 31'd100000);
        send_item(isrch_pkg::MODE_LOAD, 10'd5, '1);
        set_window(11'd6);
        send_item(isrch_pkg::MODE_SEARCH, '0, '0);
        send_item(isrch_pkg::MODE_SEARCH, '1, '1);
        send_item(isrch_pkg::MODE_SEARCH, '0, 31'd5);
        send_item(isrch_pkg::MODE_SEARCH, '0, 31'd7);
        send_item(isrch_pkg::MODE_SEARCH, '0, 31'd100000);
        // single entry window
        set_window(11'd1);
        send_item(isrch_pkg::MODE_SEARCH, '0, 31'd0);
        send_item(isrch_pkg::MODE_SEARCH, '0, 31'd5);
        // flat window: probe stays at the left end
        for (int i = 0; i < 3; i++)
            send_item(isrch_pkg::MODE_LOAD, i[isrch_pkg::IDX_W-1:0], 31'd42);
        set_window(11'd3);
        send_item(isrch_pkg::MODE_SEARCH, '0, 31'd42);
        send_item(isrch_pkg::MODE_SEARCH, '0, 31'd41);
        // unsorted contents still terminate
        send_item(isrch_pkg::MODE_LOAD, 10'd0, 31'd1);
        send_item(isrch_pkg::MODE_LOAD, 10'd1, 31'd90);
        send_item(isrch_pkg::MODE_LOAD, 10'd2, 31'd3);
        send_item(isrch_pkg::MODE_LOAD, 10'd3, 31'd50);
        set_window(11'd4);
        send_item(isrch_pkg::MODE_SEARCH, '0, 31'd3);
        send_item(isrch_pkg::MODE_SEARCH, '0, 31'd50);
    endtask

    task automatic test_full_table();
        fill_table(isrch_pkg::TABLE_DEPTH, 0, 32'd1 << 21);
        send_item(isrch_pkg::MODE_LOAD, '1, '1);
        set_window(isrch_pkg::CNT_W'(isrch_pkg::TABLE_DEPTH));
        send_item(isrch_pkg::MODE_SEARCH, '0, count_table[0]);
        send_item(isrch_pkg::MODE_SEARCH, '0, count_table[isrch_pkg::TABLE_DEPTH - 1]);
        repeat (28)
            send_item(isrch_pkg::MODE_SEARCH, isrch_pkg::IDX_W'($urandom), pick_key());
        // oversized window saturates to the table depth
        set_window('1);
        repeat (6)
            send_item(isrch_pkg::MODE_SEARCH, isrch_pkg::IDX_W'($urandom), pick_key());
    endtask

    task automatic test_random_tables();
        int          pick;
        int          n;
        int          searches;
        int unsigned span;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_FROM)
                quiet = 1'b1;
            pick = $urandom_range(0, 9);
            searches = $urandom_range(8, 30);
            if (pick == 8)
            begin
                // whole table is loaded by now, so any window is safe
                set_window(isrch_pkg::CNT_W'($urandom_range(0, 2047)));
                searches = 6;
            end
            else
            begin
                case (pick)
                    0: n = 0;
                    7: n = $urandom_range(41, 200);
                    9: n = $urandom_range(1, 4);
                    default: n = $urandom_range(1, 40);
                endcase
                case ($urandom_range(0, 3))
                    0: span = 1;
                    1: span = 16;
                    2: span = 5000;
                    default: span = 32'd1 << 22;
                endcase
                fill_table(n, $urandom_range(0, 3), span);
                set_window(n[isrch_pkg::CNT_W-1:0]);
            end
            repeat (searches)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(isrch_pkg::MODE_LOAD, isrch_pkg::IDX_W'($urandom),
                              isrch_pkg::VAL_W'($urandom));
                else
                    send_item(isrch_pkg::MODE_SEARCH, isrch_pkg::IDX_W'($urandom),
                              pick_key());
            end
        end
    endtask

    initial
    begin : result_check
        lookup_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_lookups.size() == 0)
                    report_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                              found, position));
                else
                begin
                    want = pending_lookups.pop_front();
                    if (found !== want.hit)
                        report_mismatch($sformatf("key %0d: found %0b, wanted %0b",
                                                  want.key, found, want.hit));
                    if (position !== want.where)
                        report_mismatch($sformatf("key %0d: position %0d, wanted %0d",
                                                  want.key, position, want.where));
                end
            end
        end
    end

    initial
    begin : stall_gen
        int   run_left;
        logic hold;
        run_left = 0;
        hold = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
            begin
                out_stall <= 1'b0;
                run_left = 0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    hold = ($urandom_range(0, 2) == 0);
                    run_left = hold ? $urandom_range(1, 18) : $urandom_range(1, 40);
                end
                out_stall <= hold;
                run_left--;
            end
        end
    end

    initial
    begin : main
        int      waited;
        lookup_t left_over;
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        mode = isrch_pkg::MODE_LOAD;
        index = '0;
        value = '0;
        window_entries = '0;
        mismatches = 0;
        items_sent = 0;
        quiet = 1'b0;
        waited = 0;
        for (int i = 0; i < isrch_pkg::TABLE_DEPTH; i++)
            count_table[i] = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_table();
        test_directed();
        test_full_table();
        test_random_tables();

        in_valid <= 1'b0;
        while (pending_lookups.size() != 0 && waited < 200000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (50) @(negedge clk);
        while (pending_lookups.size() != 0)
        begin
            left_over = pending_lookups.pop_front();
            report_mismatch($sformatf("no result for key %0d", left_over.key));
        end
        if (mismatches == 0)
            $display("interpolation_search_table_core_tb passed");
        else
            $display("interpolation_search_table_core_tb failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/isrch_pkg.sv
rtl/core/isrch_ram.sv
rtl/core/isrch_div.sv
rtl/core/interpolation_search_table_core.sv
test/interpolation_search_table_core_tb.sv
